// File: hdl/lzmf_pkg.sv
// Shared constants and types for the LZ77 longest match finder.
package lzmf_pkg;

    // Search geometry.
    localparam int WINDOW_MAX  = 64;
    localparam int LOOKAHEAD   = 15;
    localparam int STORE_DEPTH = 4096;
    localparam int MIN_MATCH   = 2;

    // Longest run that may be reported.
    localparam int RUN_MAX = LOOKAHEAD - 1;

    // Field and counter widths.
    localparam int OPCODE_W = 2;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int COUNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int DIST_W   = $clog2(WINDOW_MAX + 1);
    localparam int LEN_W    = $clog2(RUN_MAX + 1);
    // Read issue counter covers lookahead, window and the trailing line.
    localparam int ISS_W    = $clog2(WINDOW_MAX + 2 * RUN_MAX);

    // Operation codes.
    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_FIND   = 2'd2
    } opcode_t;

endpackage

// File: hdl/lz77_longest_match_finder.sv
// LZ77 longest match finder: byte store, read sequencer and shared compare unit.
// Clear and append transactions are accepted one per cycle while no find is in progress, and produce no result.
// A find searches distances max_d down to 1, max_d = min(position, 64), and the next
// transaction is taken once its result is loaded into the result register; the single read port
// reads 14 lookahead and max_d + 13 window bytes, one per cycle. With nothing to search
// (position 0 or beyond the stored bytes) the find goes straight to the done state.
// Reset (rst_n low, asynchronous) empties the store and clears all control state.
module lz77_longest_match_finder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lzmf_pkg::OPCODE_W-1:0]  opcode,
    input  logic [lzmf_pkg::BYTE_W-1:0]    data_byte,
    input  logic [lzmf_pkg::ADDR_W-1:0]    position,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           found,
    output logic [lzmf_pkg::DIST_W-1:0]    distance,
    output logic [lzmf_pkg::LEN_W-1:0]     match_length
);
    import lzmf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [ADDR_W-1:0]       pos_reg;
    logic [ADDR_W-1:0]       base_reg;
    logic [LEN_W-1:0]        max_len_reg;
    logic [DIST_W-1:0]       d_reg;
    logic [ISS_W-1:0]        iss_reg;
    logic [ISS_W-1:0]        total_reg;
    logic [ISS_W-1:0]        win_cnt_reg;
    logic                    rd_vld_reg;
    logic                    rd_la_reg;
    logic                    line_ok_reg;
    logic [BYTE_W-1:0]       la_reg  [RUN_MAX];
    logic [BYTE_W-1:0]       win_reg [RUN_MAX];
    logic [DIST_W-1:0]       best_d_reg;
    logic [LEN_W-1:0]        best_len_reg;
    logic                    out_valid_reg;
    logic                    found_reg;
    logic [DIST_W-1:0]       distance_reg;
    logic [LEN_W-1:0]        match_length_reg;

    // Byte store with one write and one registered read port.
    logic [BYTE_W-1:0]       store_mem [STORE_DEPTH];
    logic [BYTE_W-1:0]       mem_q;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    wr_en;

    logic                    in_take;
    logic                    out_take;
    logic                    rd_issue;
    logic [COUNT_W-1:0]      pos_ext;
    logic [COUNT_W-1:0]      remain;
    logic [LEN_W-1:0]        max_len_next;
    logic [DIST_W-1:0]       max_d_next;
    logic                    no_search;
    logic [LEN_W-1:0]        run;
    logic                    all_eq;

    assign in_take  = in_valid && (state_reg == S_IDLE);
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    // Search limits derived from the requested position.
    assign pos_ext   = {1'b0, position};
    assign remain    = count_reg - pos_ext;
    assign no_search = (pos_ext >= count_reg) || (position == '0);
    always_comb
    begin
        if (remain < COUNT_W'(RUN_MAX))
            max_len_next = remain[LEN_W-1:0];
        else
            max_len_next = LEN_W'(RUN_MAX);
        if (position < ADDR_W'(WINDOW_MAX))
            max_d_next = position[DIST_W-1:0];
        else
            max_d_next = DIST_W'(WINDOW_MAX);
    end

    // Read address: lookahead bytes first, then the window stream.
    assign rd_issue = (state_reg == S_READ) && (iss_reg < total_reg);
    always_comb
    begin
        if (iss_reg < ISS_W'(RUN_MAX))
            rd_addr = pos_reg + ADDR_W'(iss_reg);
        else
            rd_addr = base_reg + ADDR_W'(iss_reg);
    end

    assign wr_en = in_take && (opcode == OP_APPEND) && (count_reg < COUNT_W'(STORE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[count_reg[ADDR_W-1:0]] <= data_byte;
        mem_q <= store_mem[rd_addr];
    end

    // Shared compare unit: leading matching bytes of one window line, capped.
    always_comb
    begin
        run    = '0;
        all_eq = 1'b1;
        for (int k = 0; k < RUN_MAX; k++)
        begin
            all_eq = all_eq && (win_reg[k] == la_reg[k]);
            if (all_eq && (LEN_W'(k) < max_len_reg))
                run = LEN_W'(k + 1);
        end
    end

    // Sequencer, shift lines, best match and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            pos_reg          <= '0;
            base_reg         <= '0;
            max_len_reg      <= '0;
            d_reg            <= '0;
            iss_reg          <= '0;
            total_reg        <= '0;
            win_cnt_reg      <= '0;
            rd_vld_reg       <= 1'b0;
            rd_la_reg        <= 1'b0;
            line_ok_reg      <= 1'b0;
            best_d_reg       <= '0;
            best_len_reg     <= '0;
            out_valid_reg    <= 1'b0;
            found_reg        <= 1'b0;
            distance_reg     <= '0;
            match_length_reg <= '0;
            for (int j = 0; j < RUN_MAX; j++)
            begin
                la_reg[j]  <= '0;
                win_reg[j] <= '0;
            end
        end
        else
        begin
            // The done state reloads the result register itself.
            if (out_take && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            // Read pipeline bookkeeping.
            rd_vld_reg  <= rd_issue;
            rd_la_reg   <= (iss_reg < ISS_W'(RUN_MAX));
            line_ok_reg <= 1'b0;
            if (rd_issue)
                iss_reg <= iss_reg + ISS_W'(1);

            // Arriving bytes shift into the lookahead or the window line.
            if (rd_vld_reg)
            begin
                if (rd_la_reg)
                begin
                    for (int j = 0; j < RUN_MAX - 1; j++)
                        la_reg[j] <= la_reg[j+1];
                    la_reg[RUN_MAX-1] <= mem_q;
                end
                else
                begin
                    for (int j = 0; j < RUN_MAX - 1; j++)
                        win_reg[j] <= win_reg[j+1];
                    win_reg[RUN_MAX-1] <= mem_q;
                    win_cnt_reg <= win_cnt_reg + ISS_W'(1);
                    line_ok_reg <= (win_cnt_reg >= ISS_W'(RUN_MAX - 1));
                end
            end

            // One distance is judged per full window line, largest first.
            if (line_ok_reg)
            begin
                if ((run >= LEN_W'(MIN_MATCH)) && (run > best_len_reg))
                begin
                    best_len_reg <= run;
                    best_d_reg   <= d_reg;
                end
                d_reg <= d_reg - DIST_W'(1);
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        case (opcode)
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            OP_APPEND:
                            begin
                                if (wr_en)
                                    count_reg <= count_reg + COUNT_W'(1);
                            end
                            OP_FIND:
                            begin
                                pos_reg      <= position;
                                base_reg     <= position - ADDR_W'(max_d_next)
                                                - ADDR_W'(RUN_MAX);
                                max_len_reg  <= max_len_next;
                                d_reg        <= max_d_next;
                                iss_reg      <= '0;
                                win_cnt_reg  <= '0;
                                total_reg    <= ISS_W'(max_d_next) + ISS_W'(2 * RUN_MAX - 1);
                                best_d_reg   <= '0;
                                best_len_reg <= '0;
                                if (no_search)
                                    state_reg <= S_DONE;
                                else
                                    state_reg <= S_READ;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    if (line_ok_reg && (d_reg == DIST_W'(1)))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_take)
                    begin
                        out_valid_reg    <= 1'b1;
                        found_reg        <= (best_len_reg != '0);
                        distance_reg     <= best_d_reg;
                        match_length_reg <= best_len_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign distance     = distance_reg;
    assign match_length = match_length_reg;

endmodule

// File: bench/tb.sv
// Self-checking testbench for the LZ77 longest match finder.
`timescale 1ns / 100ps

module tb;
    import lzmf_pkg::*;

    // Opcode value that the block must ignore.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 1000;
    localparam int FIND_LATENCY   = 100;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [OPCODE_W-1:0]  opcode;
    logic [BYTE_W-1:0]    data_byte;
    logic [ADDR_W-1:0]    position;
    logic                 out_valid;
    logic                 out_stall;
    logic                 found;
    logic [DIST_W-1:0]    distance;
    logic [LEN_W-1:0]     match_length;

    // One expected find result.
    typedef struct {
        logic              found;
        logic [DIST_W-1:0] distance;
        logic [LEN_W-1:0]  length;
    } match_t;

    // Mirrors the byte store and keeps the expected matches in order.
    class match_scoreboard;
        logic [BYTE_W-1:0] store_bytes [STORE_DEPTH];
        int unsigned       stored;
        match_t            pending[$];
        int unsigned       errors;
        int unsigned       finds;
        int unsigned       hits;
        int unsigned       longest;
        int unsigned       farthest;

        // Update the mirrored store, or queue the longest match for a find.
        function void note_transaction(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] value,
                                       logic [ADDR_W-1:0] pos);
            int unsigned max_len;
            int unsigned max_d;
            int unsigned run;
            int unsigned p;
            match_t      m;
            p = pos;
            case (op)
                OP_CLEAR: stored = 0;
                OP_APPEND:
                begin
                    if (stored < STORE_DEPTH)
                    begin
                        store_bytes[stored] = value;
                        stored++;
                    end
                end
                OP_FIND:
                begin
                    m.found = 1'b0;
                    m.distance = '0;
                    m.length = '0;
                    if (p < stored)
                    begin
                        max_len = RUN_MAX;
                        if (stored - p < max_len)
                            max_len = stored - p;
                        max_d = (p < WINDOW_MAX) ? p : WINDOW_MAX;
                        // Largest distance first, so a tie keeps the farthest match.
                        for (int d = max_d; d >= 1; d--)
                        begin
                            run = 0;
                            while (run < max_len &&
                                   store_bytes[p + run] == store_bytes[p + run - d])
                                run++;
                            if (run >= MIN_MATCH && run > m.length)
                            begin
                                m.found = 1'b1;
                                m.length = LEN_W'(run);
                                m.distance = DIST_W'(d);
                            end
                        end
                    end
                    finds++;
                    if (m.found)
                        hits++;
                    if (m.length > longest)
                        longest = m.length;
                    if (m.distance > farthest)
                        farthest = m.distance;
                    pending.push_back(m);
                end
                default: ;
            endcase
        endfunction

        // Compare one result transaction with the oldest expected match.
        function void check_result(logic got_found, logic [DIST_W-1:0] got_dist,
                                   logic [LEN_W-1:0] got_len);
            match_t m;
            if (pending.size() == 0)
            begin
                $error("result transaction with no find waiting");
                errors++;
                return;
            end
            m = pending.pop_front();
            if (got_found !== m.found)
            begin
                $error("found: expected %0d, got %0d", m.found, got_found);
                errors++;
            end
            if (got_dist !== m.distance)
            begin
                $error("distance: expected %0d, got %0d", m.distance, got_dist);
                errors++;
            end
            if (got_len !== m.length)
            begin
                $error("match_length: expected %0d, got %0d", m.length, got_len);
                errors++;
            end
        endfunction
    endclass

    match_scoreboard sb;
    int unsigned     fill_level;
    int unsigned     items_sent;
    int unsigned     appends_sent;
    int unsigned     clears_sent;
    logic            steady;

    lz77_longest_match_finder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .data_byte    (data_byte),
        .position     (position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .distance     (distance),
        .match_length (match_length)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Monitor both channels at each edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(found, distance, match_length);
            if (in_valid && !in_stall)
                sb.note_transaction(opcode, data_byte, position);
        end
    end

    // Receiver stalls: mostly short, a few long, none in steady stretches.
    int stall_left;
    always @(posedge clk)
    begin
        if (steady)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: stall_left = $urandom_range(1, 3);
                3:       stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : 0;
                default: stall_left = 0;
            endcase
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Sender gap length: mostly short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drive one input transaction and wait until it is accepted.
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] value,
                             input logic [ADDR_W-1:0] pos);
        int gap;
        opcode    <= op;
        data_byte <= value;
        position  <= pos;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (op == OP_CLEAR)
        begin
            fill_level = 0;
            clears_sent++;
        end
        else if (op == OP_APPEND)
        begin
            if (fill_level < STORE_DEPTH)
                fill_level++;
            appends_sent++;
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every expected match has come back.
    task automatic wait_for_matches();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Append bytes that repeat a short motif built from a few random letters.
    task automatic append_pattern(input int n_bytes);
        logic [BYTE_W-1:0] letters [4];
        logic [BYTE_W-1:0] motif [70];
        logic [BYTE_W-1:0] value;
        int                n_letters;
        int                period;
        int                noise;
        n_letters = $urandom_range(1, 4);
        period = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 12);
        noise = $urandom_range(0, 2);
        for (int i = 0; i < 4; i++)
            letters[i] = BYTE_W'($urandom);
        for (int i = 0; i < period; i++)
            motif[i] = letters[$urandom_range(0, n_letters - 1)];
        for (int i = 0; i < n_bytes; i++)
        begin
            value = motif[i % period];
            if (noise == 1 && $urandom_range(0, 15) == 0)
                value = letters[$urandom_range(0, n_letters - 1)];
            else if (noise == 2 && $urandom_range(0, 3) == 0)
                value = BYTE_W'($urandom);
            send_item(OP_APPEND, value, ADDR_W'($urandom));
        end
    endtask

    // One find at a random position, sometimes past the stored bytes or ignored.
    task automatic random_find();
        int               r;
        int               low;
        logic [ADDR_W-1:0] pos;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            send_item(OP_UNUSED, BYTE_W'($urandom), ADDR_W'($urandom));
            return;
        end
        if (r < 15 || fill_level == 0)
            pos = (fill_level < STORE_DEPTH) ?
                  ADDR_W'($urandom_range(fill_level, STORE_DEPTH - 1)) : ADDR_W'($urandom);
        else if (r < 50)
        begin
            low = (fill_level > 20) ? fill_level - 20 : 0;
            pos = ADDR_W'($urandom_range(low, fill_level - 1));
        end
        else
            pos = ADDR_W'($urandom_range(0, fill_level - 1));
        send_item(OP_FIND, BYTE_W'($urandom), pos);
    endtask

    // Watchdog: end the run if nothing moves on either channel for too long.
    int idle_cycles;
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Main stimulus sequence.
    initial
    begin
        sb = new;
        steady = 1'b0;
        fill_level = 0;
        items_sent = 0;
        appends_sent = 0;
        clears_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_CLEAR;
        data_byte = '0;
        position = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Empty store, ignored opcode, then a short alternating pattern.
        send_item(OP_FIND, 8'h00, 12'd0);
        send_item(OP_FIND, 8'hFF, 12'hFFF);
        send_item(OP_UNUSED, 8'hFF, 12'hFFF);
        for (int i = 0; i < 6; i++)
            send_item(OP_APPEND, (i % 2 == 0) ? 8'h00 : 8'hFF, 12'hFFF);
        send_item(OP_FIND, 8'h00, 12'd0);
        send_item(OP_FIND, 8'h00, 12'd1);
        send_item(OP_FIND, 8'h00, 12'd2);
        send_item(OP_FIND, 8'h00, 12'd5);
        send_item(OP_FIND, 8'h00, 12'd6);
        send_item(OP_FIND, 8'h00, 12'hFFF);
        // Clear, then a one-byte period that overlaps itself.
        send_item(OP_CLEAR, 8'hFF, 12'hFFF);
        send_item(OP_FIND, 8'h00, 12'd1);
        for (int i = 0; i < 3; i++)
            send_item(OP_APPEND, 8'hAA, 12'd0);
        send_item(OP_FIND, 8'h00, 12'd1);
        send_item(OP_FIND, 8'h00, 12'd2);
        wait_for_matches();

        // Random blocks: optional clear, a patterned fill, then several finds.
        while (items_sent < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) == 0 || fill_level > 400)
                send_item(OP_CLEAR, BYTE_W'($urandom), ADDR_W'($urandom));
            append_pattern(($urandom_range(0, 9) < 7) ? $urandom_range(1, 24)
                                                      : $urandom_range(40, 100));
            repeat ($urandom_range(2, 10))
                random_find();
            if ($urandom_range(0, 9) == 0)
                wait_for_matches();
        end

        // A longer fill, then finds close to its end and past it.
        steady = 1'b0;
        send_item(OP_CLEAR, BYTE_W'($urandom), ADDR_W'($urandom));
        append_pattern(300);
        send_item(OP_FIND, BYTE_W'($urandom), 12'hFFF);
        repeat (12)
            send_item(OP_FIND, BYTE_W'($urandom),
                      ADDR_W'($urandom_range(fill_level - 20, fill_level - 1)));
        repeat (12)
            random_find();

        wait_for_matches();
        repeat (FIND_LATENCY) @(posedge clk);

        $display("Covered %0d transactions: %0d appends, %0d clears, %0d finds.",
                 items_sent, appends_sent, clears_sent, sb.finds);
        $display("%0d finds matched; longest match %0d, farthest distance %0d.",
                 sb.hits, sb.longest, sb.farthest);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
hdl/lzmf_pkg.sv
hdl/lz77_longest_match_finder.sv
bench/tb.sv
